// ===== rtl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the next-prime incremental sieve: the command
// and status bundles between the controller and the datapath, and the table
// contents after reset.
// ----------------------------------------------------------------------------
package nps_pkg;

    // Table entries present after reset: the first three primes and their seed multiples
    localparam int unsigned INIT_ENTRIES = 3;
    localparam int unsigned INIT_PRIMES [INIT_ENTRIES] = '{2, 3, 5};
    localparam int unsigned INIT_MULTS  [INIT_ENTRIES] = '{6, 9, 15};

    typedef struct packed {
        logic init_wr;    // write one reset entry of the tables
        logic load_q;     // capture the query
        logic seg_begin;  // compute segment end, restart flag clear
        logic clr_step;   // clear one sieve flag
        logic i_first;    // restart marking at prime index 1
        logic m_read;     // read prime and multiple at index i
        logic m_load;     // load multiple and step (twice the prime)
        logic m_step;     // mark one multiple and advance it
        logic m_wb;       // write back the multiple, advance i
        logic s_first;    // first candidate of the segment
        logic s_read;     // read the flag of the candidate
        logic s_append;   // append the candidate as a prime
        logic s_skip;     // drop the candidate
        logic seg_end;    // move segment start to segment end
        logic b_first;    // open the search range
        logic b_read;     // read the middle entry
        logic b_upd;      // narrow the search range
        logic f_read;     // read the entry found
        logic res_load;   // load the result register
    } nps_cmd_t;

    typedef struct packed {
        logic init_last;
        logic need_sieve;
        logic clr_last;
        logic m_lt_end;
        logic i_last;
        logic n_done;
        logic flag_set;
        logic table_full;
        logic search_done;
        logic out_free;
    } nps_status_t;

endpackage

// ===== rtl/nps_ctrl.sv =====
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller of the next-prime sieve: sequences table initialisation, segment
// sieving (clear, mark, collect) and the binary search over the prime table.
// ----------------------------------------------------------------------------
module nps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 query_valid,
    output logic                 query_ready,
    input  nps_pkg::nps_status_t st,
    output nps_pkg::nps_cmd_t    cmd
);
    import nps_pkg::*;

    typedef enum logic [11:0] {
        S_INIT  = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_CHECK = 12'b000000000100,
        S_CLR   = 12'b000000001000,
        S_MRD   = 12'b000000010000,
        S_MWAIT = 12'b000000100000,
        S_MSTEP = 12'b000001000000,
        S_SRD   = 12'b000010000000,
        S_SCHK  = 12'b000100000000,
        S_BRD   = 12'b001000000000,
        S_BCHK  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        query_ready = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (st.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                query_ready = 1'b1;
                if (query_valid)
                begin
                    cmd.load_q = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.need_sieve)
                begin
                    cmd.seg_begin = 1'b1;
                    state_next    = S_CLR;
                end
                else
                begin
                    cmd.b_first = 1'b1;
                    state_next  = S_BRD;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    cmd.i_first = 1'b1;
                    state_next  = S_MRD;
                end
            end
            S_MRD:
            begin
                cmd.m_read = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                cmd.m_load = 1'b1;
                state_next = S_MSTEP;
            end
            S_MSTEP:
            begin
                if (st.m_lt_end)
                begin
                    cmd.m_step = 1'b1;
                end
                else
                begin
                    cmd.m_wb = 1'b1;
                    if (st.i_last)
                    begin
                        cmd.s_first = 1'b1;
                        state_next  = S_SRD;
                    end
                    else
                    begin
                        state_next = S_MRD;
                    end
                end
            end
            S_SRD:
            begin
                if (st.n_done)
                begin
                    cmd.seg_end = 1'b1;
                    state_next  = S_CHECK;
                end
                else
                begin
                    cmd.s_read = 1'b1;
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (st.flag_set)
                begin
                    cmd.s_skip = 1'b1;
                    state_next = S_SRD;
                end
                else if (st.table_full)
                begin
                    // table full: stop sieving and answer from what is stored
                    cmd.seg_end = 1'b1;
                    cmd.b_first = 1'b1;
                    state_next  = S_BRD;
                end
                else
                begin
                    cmd.s_append = 1'b1;
                    state_next   = S_SRD;
                end
            end
            S_BRD:
            begin
                if (st.search_done)
                begin
                    cmd.f_read = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.b_read = 1'b1;
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                cmd.b_upd  = 1'b1;
                state_next = S_BRD;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    a_one_action_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.m_step && cmd.m_wb))
        else $error("mark step and write-back in the same cycle");

    a_seg_begin_to_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seg_begin |=> state_reg == S_CLR)
        else $error("segment start not followed by flag clear");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !st.out_free) |=> state_reg == S_DONE)
        else $error("result dropped while output stalled");

endmodule

// ===== rtl/nps_dp.sv =====
// ----------------------------------------------------------------------------
// nps_dp
// Datapath of the next-prime sieve: prime, multiple and flag memories, the
// segment and search registers, and the result register.
// ----------------------------------------------------------------------------
module nps_dp #(
    parameter int QUERY_BITS  = 16,
    parameter int TABLE_DEPTH = 16384,
    parameter int SIEVE_FLAGS = 32768
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  nps_pkg::nps_cmd_t       cmd,
    output nps_pkg::nps_status_t    st,
    input  logic [QUERY_BITS-1:0]   query,
    output logic [QUERY_BITS-1:0]   prime,
    output logic                    too_large,
    output logic                    result_valid,
    input  logic                    result_ready
);
    import nps_pkg::*;

    localparam int PW = QUERY_BITS + 1;               // prime width
    localparam int MW = QUERY_BITS + 2;               // multiple width
    localparam int CW = $clog2(TABLE_DEPTH + 1);      // count width
    localparam int AW = $clog2(TABLE_DEPTH);          // table address
    localparam int FW = $clog2(SIEVE_FLAGS);          // flag address
    localparam int HB = (QUERY_BITS + 3) / 2;         // root of multiple cap

    logic [PW-1:0] prime_mem [TABLE_DEPTH];
    logic [MW-1:0] mult_mem  [TABLE_DEPTH];
    logic          flag_mem  [SIEVE_FLAGS];

    logic [PW-1:0]         prime_rd_reg;
    logic [MW-1:0]         mult_rd_reg;
    logic                  flag_rd_reg;

    logic [QUERY_BITS-1:0] q_reg;
    logic [CW-1:0]         count_reg;
    logic [PW-1:0]         maxp_reg;
    logic [MW-1:0]         start_reg, end_reg;
    logic [QUERY_BITS:0]   clr_reg;
    logic [CW-1:0]         i_reg, lo_reg, hi_reg;
    logic [MW-1:0]         m_reg, step_reg, n_reg;
    logic [1:0]            init_reg;
    logic [QUERY_BITS-1:0] prime_reg;
    logic                  too_large_reg, result_valid_reg;

    logic [QUERY_BITS:0]   half;
    logic [CW:0]           mid_sum;
    logic [CW-1:0]         mid;
    logic [MW:0]           m_sum;
    logic [MW-1:0]         m_adv;
    logic [MW-1:0]         m_diff, n_diff;
    logic [FW-1:0]         m_idx, n_idx;
    logic [2*HB-1:0]       sq;
    logic [MW-1:0]         n_sq;
    logic                  found_big;

    assign half    = (QUERY_BITS+1)'(({1'b0, maxp_reg} + 1'b1) >> 1);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = CW'(mid_sum >> 1);
    assign m_sum   = {1'b0, m_reg} + {1'b0, step_reg};
    // saturate at the largest odd multiple the store holds
    assign m_adv   = m_sum[MW] ? {MW{1'b1}} : m_sum[MW-1:0];
    assign m_diff  = m_reg - start_reg - 1'b1;
    assign n_diff  = n_reg - start_reg - 1'b1;
    assign m_idx   = FW'(m_diff >> 1);
    assign n_idx   = FW'(n_diff >> 1);
    assign sq      = n_reg[HB-1:0] * n_reg[HB-1:0];
    assign n_sq    = ((n_reg >> HB) != '0 || (sq >> MW) != '0) ? {MW{1'b1}} : MW'(sq);
    assign found_big = (lo_reg >= count_reg) || prime_rd_reg[QUERY_BITS];

    assign st.init_last   = (init_reg == 2'(INIT_ENTRIES - 1));
    assign st.need_sieve  = ({1'b0, q_reg} > maxp_reg) && !maxp_reg[QUERY_BITS];
    assign st.clr_last    = (clr_reg == half - 1'b1);
    assign st.m_lt_end    = (m_reg < end_reg);
    assign st.i_last      = (i_reg == count_reg - 1'b1);
    assign st.n_done      = (n_reg >= end_reg);
    assign st.flag_set    = flag_rd_reg;
    assign st.table_full  = (count_reg >= CW'(TABLE_DEPTH));
    assign st.search_done = (lo_reg >= hi_reg);
    assign st.out_free    = !result_valid_reg || result_ready;

    // table memories: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
        begin
            prime_mem[AW'(init_reg)] <= PW'(INIT_PRIMES[init_reg]);
            mult_mem[AW'(init_reg)]  <= MW'(INIT_MULTS[init_reg]);
        end
        else if (cmd.s_append)
        begin
            prime_mem[AW'(count_reg)] <= PW'(n_reg);
            mult_mem[AW'(count_reg)]  <= n_sq;
        end
        else if (cmd.m_wb)
        begin
            mult_mem[AW'(i_reg)] <= m_reg;
        end
        if (cmd.m_read)
        begin
            prime_rd_reg <= prime_mem[AW'(i_reg)];
            mult_rd_reg  <= mult_mem[AW'(i_reg)];
        end
        else if (cmd.b_read)
        begin
            prime_rd_reg <= prime_mem[AW'(mid)];
        end
        else if (cmd.f_read)
        begin
            prime_rd_reg <= prime_mem[AW'(lo_reg)];
        end
    end

    // sieve flags: one per odd number of the segment
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            flag_mem[FW'(clr_reg)] <= 1'b0;
        end
        else if (cmd.m_step && m_reg > start_reg)
        begin
            flag_mem[m_idx] <= 1'b1;
        end
        if (cmd.s_read)
        begin
            flag_rd_reg <= flag_mem[n_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_q)
        begin
            q_reg <= query;
        end
        if (cmd.seg_begin)
        begin
            end_reg <= start_reg + MW'(maxp_reg) + 1'b1;
        end
        if (cmd.m_load)
        begin
            m_reg    <= mult_rd_reg;
            step_reg <= {prime_rd_reg, 1'b0};
        end
        else if (cmd.m_step)
        begin
            m_reg <= m_adv;
        end
        if (cmd.s_first)
        begin
            n_reg <= start_reg + 1'b1;
        end
        else if (cmd.s_append || cmd.s_skip)
        begin
            n_reg <= n_reg + MW'(2);
        end
        if (cmd.b_first)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        else if (cmd.b_upd)
        begin
            if (prime_rd_reg < {1'b0, q_reg})
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.res_load)
        begin
            too_large_reg <= found_big;
            prime_reg     <= found_big ? '0 : prime_rd_reg[QUERY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg         <= '0;
            count_reg        <= CW'(INIT_ENTRIES);
            maxp_reg         <= PW'(INIT_PRIMES[INIT_ENTRIES-1]);
            start_reg        <= MW'(INIT_MULTS[0]);
            clr_reg          <= '0;
            i_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_wr)
            begin
                init_reg <= init_reg + 1'b1;
            end
            if (cmd.seg_begin)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.i_first)
            begin
                i_reg <= CW'(1);
            end
            else if (cmd.m_wb)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.s_append)
            begin
                count_reg <= count_reg + 1'b1;
                maxp_reg  <= PW'(n_reg);
            end
            if (cmd.seg_end)
            begin
                start_reg <= end_reg;
            end
            if (cmd.res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign prime        = prime_reg;
    assign too_large    = too_large_reg;
    assign result_valid = result_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("prime count beyond table depth");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.s_append |-> count_reg < CW'(TABLE_DEPTH))
        else $error("append into a full table");

    a_start_even: assert property (@(posedge clk) disable iff (!rst_n)
        !start_reg[0] && maxp_reg[0])
        else $error("segment start odd or largest prime even");

    a_result_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> result_valid_reg && (too_large_reg || prime_reg >= q_reg))
        else $error("result below query");

endmodule

// ===== rtl/next_prime_incremental_sieve.sv =====
// ----------------------------------------------------------------------------
// next_prime_incremental_sieve
// Returns the smallest prime at or above a query, growing its prime table
// with a segmented sieve when the query passes the largest known prime.
//
// Usage: a query transfers on query_valid && query_ready; the answer (prime,
// too_large) transfers on result_valid && result_ready. One query is worked
// on at a time; query_ready is high while the block is idle, including while
// an earlier result still waits in the output register.
// With a warm table the answer comes from a binary search over the prime
// table, each step one registered read of the middle entry and one compare;
// the next query can transfer in the cycle in which result_valid rises.
// A query beyond the largest stored prime first sieves segments: each
// segment sets up, clears (maxp+1)/2 flags, marks the multiples of every
// stored prime from index 1 on, and reads the flag of each odd candidate.
// After reset the block writes the three seed entries before it takes a
// query. A stalled receiver holds the finished result in the output
// register; the block then finishes the next query and waits for the slot.
// ----------------------------------------------------------------------------
module next_prime_incremental_sieve #(
    parameter int QUERY_BITS  = 16,
    parameter int TABLE_DEPTH = 16384,
    parameter int SIEVE_FLAGS = 32768
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  query_valid,
    output logic                  query_ready,
    input  logic [QUERY_BITS-1:0] query,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [QUERY_BITS-1:0] prime,
    output logic                  too_large
);
    import nps_pkg::*;

    nps_cmd_t    cmd;
    nps_status_t st;

    nps_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .st          (st),
        .cmd         (cmd)
    );

    nps_dp #(
        .QUERY_BITS  (QUERY_BITS),
        .TABLE_DEPTH (TABLE_DEPTH),
        .SIEVE_FLAGS (SIEVE_FLAGS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .query        (query),
        .prime        (prime),
        .too_large    (too_large),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
